/* src/ttrc_pkg.sv */
// ----------------------------------------------------------------------------
// ttrc_pkg: shared constants for the tick to run-time clock
// Field widths, conversion constants and the reciprocals for the constant divides.
// ----------------------------------------------------------------------------
package ttrc_pkg;

  localparam int PRESCALER_W = 12;
  localparam int PERIOD_W    = 27;
  localparam int UTC_W       = 32;
  localparam int RUN_W       = 32;
  localparam int MS_W        = 10;
  localparam int M_DATA_W    = 80;

  localparam int TICK_BASE_NS = 30517;
  localparam int NS_IN_MS     = 1000000;
  localparam int MS_IN_S      = 1000;
  localparam int REM_W        = 20;

  localparam int STEP_BITS   = 16;

  // one million = 64 * 15625: drop six bits, then divide by 15625
  localparam int NS_SHIFT       = 6;
  localparam int DIV_NS_MAGIC_W = 31;
  localparam logic [DIV_NS_MAGIC_W-1:0] DIV_NS_MAGIC = 31'd1125899907;
  localparam int DIV_NS_SHIFT   = 44;

  localparam int MAGIC_W        = 29;
  localparam logic [MAGIC_W-1:0] DIV1000_MAGIC = 29'd274877907;
  localparam int DIV1000_SHIFT  = 38;
  localparam int SEC_QUO_W      = RUN_W + MAGIC_W - DIV1000_SHIFT;

endpackage

/* src/ttrc_div_ns.sv */
// ----------------------------------------------------------------------------
// ttrc_div_ns: pipelined divide of nanoseconds by one million
// Long division in 16-bit digits; each digit takes a reciprocal multiply stage
// and a remainder stage, with a side payload.
// ----------------------------------------------------------------------------
module ttrc_div_ns #(
  parameter int DIVIDEND_BITS = 51,
  parameter int SIDE_BITS = 33,
  localparam int DIGITS = (DIVIDEND_BITS + ttrc_pkg::STEP_BITS - 1) / ttrc_pkg::STEP_BITS,
  localparam int WORK_W = DIGITS * ttrc_pkg::STEP_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [DIVIDEND_BITS-1:0]   in_ns,
  input  logic [SIDE_BITS-1:0]       in_side,
  output logic                       out_valid,
  output logic [WORK_W-1:0]          out_quo,
  output logic [ttrc_pkg::REM_W-1:0] out_rem,
  output logic [SIDE_BITS-1:0]       out_side
);
  import ttrc_pkg::*;

  localparam int Y_W  = REM_W + STEP_BITS;
  localparam int Z_W  = Y_W - NS_SHIFT;
  localparam int ZP_W = DIV_NS_SHIFT + STEP_BITS;
  localparam logic [REM_W-1:0] DIVISOR = REM_W'(NS_IN_MS);

  logic                 a_valid [DIGITS];
  logic [STEP_BITS-1:0] a_quo   [DIGITS];
  logic [REM_W-1:0]     a_low   [DIGITS];
  logic [WORK_W-1:0]    a_work  [DIGITS];
  logic [SIDE_BITS-1:0] a_side  [DIGITS];
  logic                 valid_q [DIGITS];
  logic [REM_W-1:0]     rem_q   [DIGITS];
  logic [WORK_W-1:0]    work_q  [DIGITS];
  logic [SIDE_BITS-1:0] side_q  [DIGITS];

  for (genvar g = 0; g < DIGITS; g++) begin : g_stage
    logic                 v_in;
    logic [REM_W-1:0]     r_in;
    logic [WORK_W-1:0]    w_in;
    logic [SIDE_BITS-1:0] s_in;
    logic [Y_W-1:0]       y;
    logic [ZP_W-1:0]      z_prod;
    logic [REM_W-1:0]     q_back;

    if (g == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign w_in = WORK_W'(in_ns);
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = valid_q[g-1];
      assign r_in = rem_q[g-1];
      assign w_in = work_q[g-1];
      assign s_in = side_q[g-1];
    end

    assign y      = {r_in, w_in[WORK_W-1 -: STEP_BITS]};
    assign z_prod = ZP_W'(y[Y_W-1:NS_SHIFT]) * ZP_W'(DIV_NS_MAGIC);
    assign q_back = REM_W'(a_quo[g]) * DIVISOR;

    always_ff @(posedge clk) begin
      if (rst) begin
        a_valid[g] <= 1'b0;
        valid_q[g] <= 1'b0;
      end else if (en) begin
        a_valid[g] <= v_in;
        valid_q[g] <= a_valid[g];
      end
      if (en) begin
        a_quo[g]  <= z_prod[ZP_W-1:DIV_NS_SHIFT];
        a_low[g]  <= y[REM_W-1:0];
        a_work[g] <= w_in << STEP_BITS;
        a_side[g] <= s_in;
        rem_q[g]  <= a_low[g] - q_back;
        work_q[g] <= a_work[g] | WORK_W'(a_quo[g]);
        side_q[g] <= a_side[g];
      end
    end
  end

  assign out_valid = valid_q[DIGITS-1];
  assign out_quo   = work_q[DIGITS-1];
  assign out_rem   = rem_q[DIGITS-1];
  assign out_side  = side_q[DIGITS-1];

endmodule

/* src/tick_to_runtime_clock.sv */
// ----------------------------------------------------------------------------
// tick_to_runtime_clock: millisecond run-time clock from tick counter samples
// Converts wrapping tick counter samples into run time and UTC time of day.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one transaction per counter sample. s_tuser selects plain
//   report (0) or report plus UTC reference latch (1). Every input
//   transaction gives exactly one m_* transaction, in order.
//   cfg_we/cfg_wdata load the tick prescaler; write it only while idle.
// Pipeline: m_tvalid is registered after the input, multiply, nanosecond divider
//   (two stages per 16-bit digit), accumulate and seconds stages and the
//   output register.
// Throughput: one transaction per cycle while m_tready is high.
// Stall: a held result waits in the output register and one more in a
//   skid register; the pipeline and s_tready hold while the skid is full.
// Reset: prescaler 0, counter history, run time, leftover nanoseconds and
//   UTC reference all zero; the pipeline is emptied.
// ----------------------------------------------------------------------------
module tick_to_runtime_clock #(
  parameter int COUNTER_BITS = 24,
  localparam int S_DATA_W = ((COUNTER_BITS + ttrc_pkg::UTC_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ttrc_pkg::PRESCALER_W-1:0] cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [S_DATA_W-1:0]              s_tdata,   // counter_value, utc_seconds
  input  logic [0:0]                       s_tuser,   // func
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ttrc_pkg::M_DATA_W-1:0]    m_tdata    // run_time_ms, utc_now_seconds, ms_in_second
);
  import ttrc_pkg::*;

  localparam int NS_W   = COUNTER_BITS + PERIOD_W;
  localparam int DIV_W  = ((NS_W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int SIDE_W = UTC_W + 1;
  localparam int PROD_W = RUN_W + MAGIC_W;

  logic en;
  logic accept;

  // configuration
  logic [PERIOD_W-1:0] period;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_W'(TICK_BASE_NS);
    end else if (cfg_we) begin
      period <= (PERIOD_W'(cfg_wdata) + PERIOD_W'(1)) * PERIOD_W'(TICK_BASE_NS);
    end
  end

  // input stage: tick difference
  logic [COUNTER_BITS-1:0] now;
  logic [COUNTER_BITS-1:0] last_counter;
  logic [COUNTER_BITS-1:0] d_diff;
  logic                    d_valid;
  logic                    d_func;
  logic [UTC_W-1:0]        d_utc;

  assign now      = s_tdata[COUNTER_BITS-1:0];
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_counter <= '0;
      d_valid      <= 1'b0;
    end else if (en) begin
      d_valid <= s_tvalid;
      if (accept) begin
        last_counter <= now;
      end
    end
    if (en) begin
      d_diff <= now - last_counter;
      d_func <= s_tuser[0];
      d_utc  <= s_tdata[COUNTER_BITS +: UTC_W];
    end
  end

  // multiply stage: ticks to nanoseconds
  logic            p_valid;
  logic [NS_W-1:0] p_ns;
  logic            p_func;
  logic [UTC_W-1:0] p_utc;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= d_valid;
    end
    if (en) begin
      p_ns   <= NS_W'(d_diff) * NS_W'(period);
      p_func <= d_func;
      p_utc  <= d_utc;
    end
  end

  // nanoseconds to whole milliseconds and remainder
  logic              div_valid;
  logic [DIV_W-1:0]  div_quo;
  logic [REM_W-1:0]  div_rem;
  logic [SIDE_W-1:0] div_side;
  logic              div_func;
  logic [UTC_W-1:0]  div_utc;

  ttrc_div_ns #(
    .DIVIDEND_BITS(NS_W),
    .SIDE_BITS(SIDE_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(p_valid),
    .in_ns(p_ns),
    .in_side({p_func, p_utc}),
    .out_valid(div_valid),
    .out_quo(div_quo),
    .out_rem(div_rem),
    .out_side(div_side)
  );

  assign div_func = div_side[UTC_W];
  assign div_utc  = div_side[UTC_W-1:0];

  // accumulate stage: run-time state
  logic [RUN_W-1:0] elapsed_ms;
  logic [REM_W-1:0] leftover_ns;
  logic [UTC_W-1:0] reference_utc;
  logic [RUN_W-1:0] reference_ms;
  logic [REM_W:0]   rest_sum;
  logic             rest_carry;
  logic [REM_W:0]   rest_next;
  logic [RUN_W-1:0] elapsed_ms_next;

  logic             a_valid;
  logic [RUN_W-1:0] a_run;
  logic [RUN_W-1:0] a_since;
  logic [UTC_W-1:0] a_ref;

  assign rest_sum        = {1'b0, leftover_ns} + {1'b0, div_rem};
  assign rest_carry      = rest_sum >= (REM_W + 1)'(NS_IN_MS);
  assign rest_next       = rest_carry ? rest_sum - (REM_W + 1)'(NS_IN_MS) : rest_sum;
  assign elapsed_ms_next = elapsed_ms + div_quo[RUN_W-1:0] + RUN_W'(rest_carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms    <= '0;
      leftover_ns   <= '0;
      reference_utc <= '0;
      reference_ms  <= '0;
      a_valid       <= 1'b0;
    end else if (en) begin
      a_valid <= div_valid;
      if (div_valid) begin
        elapsed_ms  <= elapsed_ms_next;
        leftover_ns <= rest_next[REM_W-1:0];
        if (div_func) begin
          reference_utc <= div_utc;
          reference_ms  <= elapsed_ms_next;
        end
      end
    end
    if (en) begin
      a_run   <= elapsed_ms_next;
      a_since <= div_func ? '0 : elapsed_ms_next - reference_ms;
      a_ref   <= div_func ? div_utc : reference_utc;
    end
  end

  // seconds stage: since / 1000 by reciprocal
  logic [PROD_W-1:0]    b_prod;
  logic                 b_valid;
  logic [SEC_QUO_W-1:0] b_quo;
  logic [RUN_W-1:0]     b_since;
  logic [RUN_W-1:0]     b_run;
  logic [UTC_W-1:0]     b_ref;

  assign b_prod = PROD_W'(a_since) * PROD_W'(DIV1000_MAGIC);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_quo   <= b_prod[PROD_W-1:DIV1000_SHIFT];
      b_since <= a_since;
      b_run   <= a_run;
      b_ref   <= a_ref;
    end
  end

  // result formatting
  logic [RUN_W-1:0]    c_back;
  logic [RUN_W-1:0]    c_ms_full;
  logic [UTC_W-1:0]    c_utc;
  logic [M_DATA_W-1:0] c_data;

  assign c_back    = RUN_W'(b_quo) * RUN_W'(MS_IN_S);
  assign c_ms_full = b_since - c_back;
  assign c_utc     = b_ref + UTC_W'(b_quo);
  assign c_data    = M_DATA_W'({c_ms_full[MS_W-1:0], c_utc, b_run});

  // output register and skid
  logic                skid_valid;
  logic [M_DATA_W-1:0] skid_data;
  logic                push;
  logic                out_take;

  assign en       = !skid_valid;
  assign push     = en && b_valid;
  assign out_take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
    if (out_take) begin
      m_tdata <= skid_valid ? skid_data : c_data;
    end else if (push) begin
      skid_data <= c_data;
    end
  end

endmodule
